### sv/mfd_pkg.sv
`timescale 1ns / 1ps

package mfd_pkg;

  // Longest message that still reports a normal status
  localparam int unsigned MAX_FRAME_BYTES = 65536;
  // Byte counter saturates at MAX_FRAME_BYTES + 1
  localparam int unsigned CNT_W = $clog2(MAX_FRAME_BYTES + 2);

  // Parser phases
  localparam logic [3:0] PH_KIND      = 4'd0;
  localparam logic [3:0] PH_SEQ       = 4'd1;
  localparam logic [3:0] PH_TOPIC_LEN = 4'd2;
  localparam logic [3:0] PH_TOPIC     = 4'd3;
  localparam logic [3:0] PH_SVC_LEN   = 4'd4;
  localparam logic [3:0] PH_SVC       = 4'd5;
  localparam logic [3:0] PH_TYPE_LEN  = 4'd6;
  localparam logic [3:0] PH_TYPE      = 4'd7;
  localparam logic [3:0] PH_PSIZE     = 4'd8;
  localparam logic [3:0] PH_PAYLOAD   = 4'd9;
  localparam logic [3:0] PH_DONE      = 4'd10;
  localparam logic [3:0] PH_SKIP      = 4'd11;

  // Field tags
  localparam logic [3:0] TAG_KIND      = 4'd0;
  localparam logic [3:0] TAG_TOPIC_LEN = 4'd1;
  localparam logic [3:0] TAG_TOPIC     = 4'd2;
  localparam logic [3:0] TAG_TYPE_LEN  = 4'd3;
  localparam logic [3:0] TAG_TYPE      = 4'd4;
  localparam logic [3:0] TAG_SEQ       = 4'd5;
  localparam logic [3:0] TAG_SVC_LEN   = 4'd6;
  localparam logic [3:0] TAG_SVC       = 4'd7;
  localparam logic [3:0] TAG_PSIZE     = 4'd8;
  localparam logic [3:0] TAG_PAYLOAD   = 4'd9;
  localparam logic [3:0] TAG_IGNORED   = 4'd10;

  // Frame status
  localparam logic [2:0] STAT_OK       = 3'd0;
  localparam logic [2:0] STAT_KIND     = 3'd1;
  localparam logic [2:0] STAT_TRUNC    = 3'd2;
  localparam logic [2:0] STAT_MISMATCH = 3'd3;
  localparam logic [2:0] STAT_TOO_LONG = 3'd4;

  // Frame kinds
  localparam logic [1:0] KIND_PUBLISH  = 2'd0;
  localparam logic [1:0] KIND_REQUEST  = 2'd1;
  localparam logic [1:0] KIND_RESPONSE = 2'd2;
  localparam logic [1:0] KIND_UNKNOWN  = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] REG_PUBLISH  = 2'd0;
  localparam logic [1:0] REG_REQUEST  = 2'd1;
  localparam logic [1:0] REG_RESPONSE = 2'd2;

  typedef struct packed {
    logic [7:0]  byte_out;
    logic [3:0]  field_tag;
    logic        frame_end;
    logic [2:0]  frame_status;
    logic [1:0]  frame_kind;
    logic [31:0] sequence_id;
    logic [31:0] payload_length;
  } result_t;

  // Phase that follows a string body
  function automatic logic [3:0] after_string(input logic [3:0] body);
    return (body == PH_TYPE) ? PH_PSIZE : PH_TYPE_LEN;
  endfunction

endpackage

### sv/message_frame_deframer_unit.sv
`timescale 1ns / 1ps

// Byte-serial frame parser: takes one message byte per cycle while in_stall is
// low and returns one registered result word per byte, with the byte echoed and
// tagged by field; the word of the last byte also carries status, kind,
// sequence id and payload size. Sustained rate is one byte per clock while the
// output does not stall; the phase update between the parser state and the
// result register is combinational. A skid register behind the result register
// lets the input take one more byte after the output stalls. Kind codes are to be
// written through the cfg port while no frame is in flight; the block does not enforce it.
module message_frame_deframer_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  byte_out,
  output logic [3:0]  field_tag,
  output logic        frame_end,
  output logic [2:0]  frame_status,
  output logic [1:0]  frame_kind,
  output logic [31:0] sequence_id,
  output logic [31:0] payload_length
);

  localparam logic [mfd_pkg::CNT_W-1:0] MAX_CNT = mfd_pkg::CNT_W'(mfd_pkg::MAX_FRAME_BYTES);

  logic [7:0] publish_code, request_code, response_code;

  logic [3:0]  phase, phase_next;
  logic [1:0]  fbi, fbi_next;
  logic [15:0] str_rem, str_rem_next;
  logic [31:0] pay_rem, pay_rem_next;
  logic [31:0] seq, seq_next;
  logic [31:0] size, size_next;
  logic [1:0]  kind, kind_next;
  logic        kind_err, kind_err_next;
  logic        overrun, overrun_next;
  logic [mfd_pkg::CNT_W-1:0] count, count_next;

  mfd_pkg::result_t res, out_word, skid_word;
  logic skid_valid;
  logic in_acc;

  assign in_stall = skid_valid;
  assign in_acc   = in_valid && !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      publish_code  <= 8'd0;
      request_code  <= 8'd1;
      response_code <= 8'd2;
    end else if (cfg_we) begin
      case (cfg_index)
        mfd_pkg::REG_PUBLISH:  publish_code  <= cfg_data;
        mfd_pkg::REG_REQUEST:  request_code  <= cfg_data;
        mfd_pkg::REG_RESPONSE: response_code <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [15:0] str_dec;
    logic [31:0] pay_dec;
    phase_next    = phase;
    fbi_next      = fbi;
    str_rem_next  = str_rem;
    pay_rem_next  = pay_rem;
    seq_next      = seq;
    size_next     = size;
    kind_next     = kind;
    kind_err_next = kind_err;
    overrun_next  = overrun;
    count_next    = (count <= MAX_CNT) ? count + mfd_pkg::CNT_W'(1) : count;
    str_dec       = (str_rem != 16'd0) ? str_rem - 16'd1 : str_rem;
    pay_dec       = (pay_rem != 32'd0) ? pay_rem - 32'd1 : pay_rem;
    res           = '0;
    res.field_tag = mfd_pkg::TAG_IGNORED;

    case (phase)
      mfd_pkg::PH_KIND: begin
        res.field_tag = mfd_pkg::TAG_KIND;
        fbi_next = 2'd0;
        if (data_byte == publish_code) begin
          kind_next  = mfd_pkg::KIND_PUBLISH;
          phase_next = mfd_pkg::PH_TOPIC_LEN;
        end else if (data_byte == request_code) begin
          kind_next  = mfd_pkg::KIND_REQUEST;
          phase_next = mfd_pkg::PH_SEQ;
        end else if (data_byte == response_code) begin
          kind_next  = mfd_pkg::KIND_RESPONSE;
          phase_next = mfd_pkg::PH_SEQ;
        end else begin
          kind_next     = mfd_pkg::KIND_UNKNOWN;
          kind_err_next = 1'b1;
          phase_next    = mfd_pkg::PH_SKIP;
        end
      end
      mfd_pkg::PH_SEQ: begin
        res.field_tag = mfd_pkg::TAG_SEQ;
        seq_next = {seq[23:0], data_byte};
        if (fbi == 2'd3) begin
          fbi_next   = 2'd0;
          phase_next = (kind == mfd_pkg::KIND_REQUEST) ? mfd_pkg::PH_SVC_LEN
                                                       : mfd_pkg::PH_TYPE_LEN;
        end else begin
          fbi_next = fbi + 2'd1;
        end
      end
      mfd_pkg::PH_TOPIC_LEN, mfd_pkg::PH_SVC_LEN, mfd_pkg::PH_TYPE_LEN: begin
        res.field_tag = (phase == mfd_pkg::PH_TOPIC_LEN) ? mfd_pkg::TAG_TOPIC_LEN :
                        (phase == mfd_pkg::PH_SVC_LEN)   ? mfd_pkg::TAG_SVC_LEN :
                                                           mfd_pkg::TAG_TYPE_LEN;
        str_rem_next = {str_rem[7:0], data_byte};
        if (fbi != 2'd0) begin
          fbi_next = 2'd0;
          // an empty string skips its body
          phase_next = ({str_rem[7:0], data_byte} != 16'd0) ? phase + 4'd1
                       : mfd_pkg::after_string(phase + 4'd1);
        end else begin
          fbi_next = 2'd1;
        end
      end
      mfd_pkg::PH_TOPIC, mfd_pkg::PH_SVC, mfd_pkg::PH_TYPE: begin
        res.field_tag = (phase == mfd_pkg::PH_TOPIC) ? mfd_pkg::TAG_TOPIC :
                        (phase == mfd_pkg::PH_SVC)   ? mfd_pkg::TAG_SVC :
                                                       mfd_pkg::TAG_TYPE;
        str_rem_next = str_dec;
        if (str_dec == 16'd0) phase_next = mfd_pkg::after_string(phase);
      end
      mfd_pkg::PH_PSIZE: begin
        res.field_tag = mfd_pkg::TAG_PSIZE;
        size_next    = {size[23:0], data_byte};
        pay_rem_next = {size[23:0], data_byte};
        if (fbi == 2'd3) begin
          fbi_next   = 2'd0;
          phase_next = ({size[23:0], data_byte} != 32'd0) ? mfd_pkg::PH_PAYLOAD
                                                          : mfd_pkg::PH_DONE;
        end else begin
          fbi_next = fbi + 2'd1;
        end
      end
      mfd_pkg::PH_PAYLOAD: begin
        res.field_tag = mfd_pkg::TAG_PAYLOAD;
        pay_rem_next  = pay_dec;
        if (pay_dec == 32'd0) phase_next = mfd_pkg::PH_DONE;
      end
      mfd_pkg::PH_DONE: begin
        res.field_tag = mfd_pkg::TAG_IGNORED;
        overrun_next  = 1'b1;
      end
      default: res.field_tag = mfd_pkg::TAG_IGNORED;
    endcase

    res.byte_out  = data_byte;
    res.frame_end = last_byte;

    if (last_byte) begin
      if (count_next > MAX_CNT)             res.frame_status = mfd_pkg::STAT_TOO_LONG;
      else if (kind_err_next)               res.frame_status = mfd_pkg::STAT_KIND;
      else if (phase_next == mfd_pkg::PH_DONE)
        res.frame_status = overrun_next ? mfd_pkg::STAT_MISMATCH : mfd_pkg::STAT_OK;
      else if (phase_next == mfd_pkg::PH_PAYLOAD) res.frame_status = mfd_pkg::STAT_MISMATCH;
      else                                  res.frame_status = mfd_pkg::STAT_TRUNC;
      res.frame_kind     = kind_next;
      res.sequence_id    = (kind_next == mfd_pkg::KIND_REQUEST ||
                            kind_next == mfd_pkg::KIND_RESPONSE) ? seq_next : 32'd0;
      res.payload_length = size_next;
      // drop all frame state for the next message
      phase_next    = mfd_pkg::PH_KIND;
      fbi_next      = 2'd0;
      str_rem_next  = 16'd0;
      pay_rem_next  = 32'd0;
      seq_next      = 32'd0;
      size_next     = 32'd0;
      kind_next     = mfd_pkg::KIND_PUBLISH;
      kind_err_next = 1'b0;
      overrun_next  = 1'b0;
      count_next    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= mfd_pkg::PH_KIND;
      fbi      <= 2'd0;
      str_rem  <= 16'd0;
      pay_rem  <= 32'd0;
      seq      <= 32'd0;
      size     <= 32'd0;
      kind     <= mfd_pkg::KIND_PUBLISH;
      kind_err <= 1'b0;
      overrun  <= 1'b0;
      count    <= '0;
    end else if (in_acc) begin
      phase    <= phase_next;
      fbi      <= fbi_next;
      str_rem  <= str_rem_next;
      pay_rem  <= pay_rem_next;
      seq      <= seq_next;
      size     <= size_next;
      kind     <= kind_next;
      kind_err <= kind_err_next;
      overrun  <= overrun_next;
      count    <= count_next;
    end
  end

  // output register with one skid word behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_acc;
      end
    end else if (in_acc) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      if (skid_valid) out_word <= skid_word;
      else if (in_acc) out_word <= res;
    end else if (in_acc) begin
      skid_word <= res;
    end
  end

  assign byte_out       = out_word.byte_out;
  assign field_tag      = out_word.field_tag;
  assign frame_end      = out_word.frame_end;
  assign frame_status   = out_word.frame_status;
  assign frame_kind     = out_word.frame_kind;
  assign sequence_id    = out_word.sequence_id;
  assign payload_length = out_word.payload_length;

endmodule

### sv/mfd_checker.sv
`timescale 1ns / 1ps

module mfd_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [3:0]  field_tag,
  input logic        frame_end,
  input logic [2:0]  frame_status,
  input logic [1:0]  frame_kind,
  input logic [31:0] sequence_id,
  input logic [31:0] payload_length
);

  // a stalled word stays offered
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("output word dropped while stalled");

  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // header fields are only reported on the last byte
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !frame_end |->
      frame_status == mfd_pkg::STAT_OK && frame_kind == mfd_pkg::KIND_PUBLISH &&
      sequence_id == 32'd0 && payload_length == 32'd0)
    else $error("header fields set on a word that is not the last");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_end && frame_kind == mfd_pkg::KIND_UNKNOWN |->
      frame_status == mfd_pkg::STAT_KIND || frame_status == mfd_pkg::STAT_TOO_LONG)
    else $error("unknown kind reported with wrong status");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && (frame_kind == mfd_pkg::KIND_PUBLISH ||
                  frame_kind == mfd_pkg::KIND_UNKNOWN) |-> sequence_id == 32'd0)
    else $error("sequence id on a frame that has none");

endmodule

bind message_frame_deframer_unit mfd_checker u_mfd_checker (.*);
